// ----- rtl/dpfm_pkg.sv -----
`timescale 1ns / 1ps
package dpfm_pkg;

    localparam int ADC_W      = 12;
    localparam int CV_ENTRIES = 16;
    localparam int CV_IDX_W   = $clog2(CV_ENTRIES);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int DIV_W      = 32;
    localparam int SQ_IN_W    = 44;
    localparam int SQ_OUT_W   = SQ_IN_W / 2;
    localparam logic [19:0] FLOW_MAX = 20'hFFFFF;

    localparam logic [2:0] CFG_POT_MIN        = 3'd0;
    localparam logic [2:0] CFG_POT_MAX        = 3'd1;
    localparam logic [2:0] CFG_CV_ENTRIES     = 3'd2;
    localparam logic [2:0] CFG_ADC_FULL_SCALE = 3'd3;
    localparam logic [2:0] CFG_FULL_SCALE_PSI = 3'd4;
    localparam logic [2:0] CFG_SG_RECIP       = 3'd5;
    localparam logic [2:0] CFG_GAL_TO_ML      = 3'd6;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] up_neg;
        logic [11:0] up_pos;
        logic [11:0] down_neg;
        logic [11:0] down_pos;
        logic [11:0] pot_reading;
        logic [3:0]  cv_index;
        logic [15:0] cv_entry;
    } item_t;

    typedef struct packed {
        logic [11:0] pot_min;
        logic [11:0] pot_max;
        logic [4:0]  cv_entries_used;
        logic [11:0] adc_full_scale;
        logic [15:0] full_scale_psi;
        logic [15:0] sg_recip;
        logic [15:0] gal_to_ml;
    } cfg_t;

    typedef struct packed {
        logic [15:0] upstream_psi;
        logic [15:0] downstream_psi;
        logic [15:0] cv_interp;
        logic [19:0] flow_ml_min;
        logic        flow_saturated;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_GO,
        ST_UP_WAIT,
        ST_DN_GO,
        ST_DN_WAIT,
        ST_POS,
        ST_IDX_WAIT,
        ST_RD_A,
        ST_RD_B,
        ST_INTERP,
        ST_CV_WAIT,
        ST_DP,
        ST_SQ_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } back_state_t;

endpackage

// ----- rtl/dpfm_front.sv -----
`timescale 1ns / 1ps
module dpfm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,
    input  logic                 s_tuser,
    input  dpfm_pkg::fifo_stat_t fifo_stat,
    output logic                 push,
    output dpfm_pkg::item_t      push_item,
    output logic                 held
);

    logic            vld_reg;
    dpfm_pkg::item_t item_reg;
    logic            take;

    assign s_tready  = !vld_reg || !fifo_stat.full;
    assign take      = s_tvalid && s_tready;
    assign push      = vld_reg && !fifo_stat.full;
    assign push_item = item_reg;
    assign held      = vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (push)
        begin
            vld_reg <= 1'b0;
        end
    end

    // classify on entry: tuser selects sample or table load
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op          <= dpfm_pkg::op_t'(s_tuser);
            item_reg.up_neg      <= s_tdata[11:0];
            item_reg.up_pos      <= s_tdata[23:12];
            item_reg.down_neg    <= s_tdata[35:24];
            item_reg.down_pos    <= s_tdata[47:36];
            item_reg.pot_reading <= s_tdata[59:48];
            item_reg.cv_index    <= s_tdata[63:60];
            item_reg.cv_entry    <= s_tdata[79:64];
        end
    end

endmodule

// ----- rtl/dpfm_fifo.sv -----
`timescale 1ns / 1ps
module dpfm_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpfm_pkg::item_t      push_item,
    input  logic                 pop,
    output dpfm_pkg::item_t      head,
    output dpfm_pkg::fifo_stat_t stat
);

    dpfm_pkg::item_t                     mem [dpfm_pkg::FIFO_DEPTH];
    logic [dpfm_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [dpfm_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [dpfm_pkg::FIFO_PTR_W:0]       cnt_reg;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (dpfm_pkg::FIFO_PTR_W+1)'(dpfm_pkg::FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/dpfm_div.sv -----
`timescale 1ns / 1ps
module dpfm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dpfm_pkg::DIV_W-1:0] dividend,
    input  logic [11:0]                divisor,
    output logic                       done,
    output logic [dpfm_pkg::DIV_W-1:0] quot,
    output logic [11:0]                rem
);

    localparam int CNT_W = $clog2(dpfm_pkg::DIV_W + 1);

    logic [dpfm_pkg::DIV_W-1:0] q_reg;
    logic [11:0]                r_reg;
    logic [11:0]                d_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [12:0]                trial;
    logic                       ge;

    // restoring division, one quotient bit per cycle
    assign trial = {r_reg, q_reg[dpfm_pkg::DIV_W-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign done  = done_reg;
    assign quot  = q_reg;
    assign rem   = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(dpfm_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[dpfm_pkg::DIV_W-2:0], ge};
            r_reg <= ge ? 12'(trial - {1'b0, d_reg}) : trial[11:0];
        end
    end

endmodule

// ----- rtl/dpfm_sqrt.sv -----
`timescale 1ns / 1ps
module dpfm_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dpfm_pkg::SQ_IN_W-1:0]  value,
    output logic                          done,
    output logic [dpfm_pkg::SQ_OUT_W-1:0] root
);

    localparam int RW    = dpfm_pkg::SQ_OUT_W + 4;
    localparam int CNT_W = $clog2(dpfm_pkg::SQ_OUT_W + 1);

    logic [dpfm_pkg::SQ_IN_W-1:0]  v_reg;
    logic [RW-1:0]                 rem_reg;
    logic [dpfm_pkg::SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [RW-1:0]                 rem_sh;
    logic [RW-1:0]                 trial;
    logic                          ge;

    // digit-by-digit root, two radicand bits per cycle
    assign rem_sh = {rem_reg[RW-3:0], v_reg[dpfm_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(dpfm_pkg::SQ_OUT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[dpfm_pkg::SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[dpfm_pkg::SQ_OUT_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/dpfm_back.sv -----
`timescale 1ns / 1ps
module dpfm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpfm_pkg::cfg_t       cfg,
    input  dpfm_pkg::fifo_stat_t fifo_stat,
    input  dpfm_pkg::item_t      head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dpfm_pkg::result_t    out_res
);

    dpfm_pkg::back_state_t state_reg, state_next;

    dpfm_pkg::item_t                 item_reg;
    logic [11:0]                     raw_up_reg, raw_dn_reg;
    logic [15:0]                     up_reg, dn_reg;
    logic [11:0]                     span_reg;
    logic [dpfm_pkg::CV_IDX_W-1:0]   idx_reg;
    logic [11:0]                     r_reg;
    logic [15:0]                     a_reg;
    logic                            neg_reg;
    logic [15:0]                     cv_reg;
    logic [dpfm_pkg::SQ_OUT_W-1:0]   s_reg;
    logic [37:0]                     p1_reg;
    logic [53:0]                     p2_reg;
    logic                            out_vld_reg;
    dpfm_pkg::result_t               out_reg;

    logic [15:0] cv_mem [dpfm_pkg::CV_ENTRIES];
    logic [15:0] rdata_reg;
    logic [dpfm_pkg::CV_IDX_W-1:0] rd_addr;

    logic                       div_start, div_done;
    logic [dpfm_pkg::DIV_W-1:0] div_dividend, div_quot;
    logic [11:0]                div_divisor, div_rem;
    logic                       sq_start, sq_done;
    logic [dpfm_pkg::SQ_IN_W-1:0]  sq_value;
    logic [dpfm_pkg::SQ_OUT_W-1:0] sq_root;

    logic [11:0] den;
    logic        fwd;
    logic [11:0] lo, hi, pc, span, off;
    logic [4:0]  n_cl;
    logic [3:0]  nm1;
    logic [15:0] q;
    logic [15:0] b_val, diff;
    logic [15:0] dp;
    logic [15:0] quot16;
    logic        sat;
    logic        out_free;

    assign out_free  = !out_vld_reg || out_ready;
    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;
    assign pop       = (state_reg == dpfm_pkg::ST_IDLE) && !fifo_stat.empty;
    assign quot16    = div_quot[15:0];

    // scaling and position arithmetic
    always_comb
    begin
        den  = (cfg.adc_full_scale == '0) ? 12'd1 : cfg.adc_full_scale;
        fwd  = cfg.pot_min < cfg.pot_max;
        lo   = fwd ? cfg.pot_min : cfg.pot_max;
        hi   = fwd ? cfg.pot_max : cfg.pot_min;
        if (item_reg.pot_reading < lo)
        begin
            pc = lo;
        end
        else if (item_reg.pot_reading > hi)
        begin
            pc = hi;
        end
        else
        begin
            pc = item_reg.pot_reading;
        end
        span = hi - lo;
        off  = fwd ? (pc - cfg.pot_min) : (cfg.pot_min - pc);
        if (cfg.cv_entries_used < 5'd2)
        begin
            n_cl = 5'd2;
        end
        else if (cfg.cv_entries_used > 5'(dpfm_pkg::CV_ENTRIES))
        begin
            n_cl = 5'(dpfm_pkg::CV_ENTRIES);
        end
        else
        begin
            n_cl = cfg.cv_entries_used;
        end
        nm1   = 4'(n_cl - 5'd1);
        q     = 16'({4'b0, off} * {12'b0, nm1});
        // upper neighbor past the table end reads as zero
        b_val = (idx_reg == dpfm_pkg::CV_IDX_W'(dpfm_pkg::CV_ENTRIES - 1)) ? 16'd0 : rdata_reg;
        diff  = (b_val >= a_reg) ? (b_val - a_reg) : (a_reg - b_val);
        dp    = (up_reg > dn_reg) ? (up_reg - dn_reg) : (dn_reg - up_reg);
        sat   = |p2_reg[53:44];
    end

    // divider, root and memory port steering
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = den;
        sq_start     = 1'b0;
        sq_value     = {32'({16'b0, dp} * {16'b0, cfg.sg_recip}), 12'b0};
        rd_addr      = idx_reg;
        case (state_reg)
            dpfm_pkg::ST_UP_GO:
            begin
                div_start    = 1'b1;
                div_dividend = 32'({16'b0, 4'b0, raw_up_reg} * {16'b0, cfg.full_scale_psi});
            end
            dpfm_pkg::ST_DN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = 32'({16'b0, 4'b0, raw_dn_reg} * {16'b0, cfg.full_scale_psi});
            end
            dpfm_pkg::ST_POS:
            begin
                div_start    = (span != '0);
                div_dividend = {16'b0, q};
                div_divisor  = span;
            end
            dpfm_pkg::ST_RD_B:
            begin
                rd_addr = idx_reg + 1'b1;
            end
            dpfm_pkg::ST_INTERP:
            begin
                div_start    = (r_reg != '0);
                div_dividend = 32'({16'b0, 4'b0, r_reg} * {16'b0, diff});
                div_divisor  = span_reg;
            end
            dpfm_pkg::ST_DP:
            begin
                sq_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpfm_pkg::ST_IDLE:
                if (pop && head.op == dpfm_pkg::OP_SAMPLE)
                begin
                    state_next = dpfm_pkg::ST_UP_GO;
                end
            dpfm_pkg::ST_UP_GO:   state_next = dpfm_pkg::ST_UP_WAIT;
            dpfm_pkg::ST_UP_WAIT:
                if (div_done)
                begin
                    state_next = dpfm_pkg::ST_DN_GO;
                end
            dpfm_pkg::ST_DN_GO:   state_next = dpfm_pkg::ST_DN_WAIT;
            dpfm_pkg::ST_DN_WAIT:
                if (div_done)
                begin
                    state_next = dpfm_pkg::ST_POS;
                end
            dpfm_pkg::ST_POS:
                state_next = (span != '0) ? dpfm_pkg::ST_IDX_WAIT : dpfm_pkg::ST_RD_A;
            dpfm_pkg::ST_IDX_WAIT:
                if (div_done)
                begin
                    state_next = dpfm_pkg::ST_RD_A;
                end
            dpfm_pkg::ST_RD_A:    state_next = dpfm_pkg::ST_RD_B;
            dpfm_pkg::ST_RD_B:    state_next = dpfm_pkg::ST_INTERP;
            dpfm_pkg::ST_INTERP:
                state_next = (r_reg != '0) ? dpfm_pkg::ST_CV_WAIT : dpfm_pkg::ST_DP;
            dpfm_pkg::ST_CV_WAIT:
                if (div_done)
                begin
                    state_next = dpfm_pkg::ST_DP;
                end
            dpfm_pkg::ST_DP:      state_next = dpfm_pkg::ST_SQ_WAIT;
            dpfm_pkg::ST_SQ_WAIT:
                if (sq_done)
                begin
                    state_next = dpfm_pkg::ST_MUL1;
                end
            dpfm_pkg::ST_MUL1:    state_next = dpfm_pkg::ST_MUL2;
            dpfm_pkg::ST_MUL2:    state_next = dpfm_pkg::ST_OUT;
            dpfm_pkg::ST_OUT:
                if (out_free)
                begin
                    state_next = dpfm_pkg::ST_IDLE;
                end
            default:              state_next = dpfm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dpfm_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dpfm_pkg::ST_OUT && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= cv_mem[rd_addr];
        if (pop && head.op == dpfm_pkg::OP_LOAD)
        begin
            cv_mem[head.cv_index] <= head.cv_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            dpfm_pkg::ST_IDLE:
            begin
                item_reg   <= head;
                raw_up_reg <= (head.up_pos > head.up_neg) ? (head.up_pos - head.up_neg)
                                                          : (head.up_neg - head.up_pos);
                raw_dn_reg <= (head.down_pos > head.down_neg) ? (head.down_pos - head.down_neg)
                                                              : (head.down_neg - head.down_pos);
            end
            dpfm_pkg::ST_UP_WAIT:
                if (div_done)
                begin
                    up_reg <= (|div_quot[31:16]) ? 16'hFFFF : quot16;
                end
            dpfm_pkg::ST_DN_WAIT:
                if (div_done)
                begin
                    dn_reg <= (|div_quot[31:16]) ? 16'hFFFF : quot16;
                end
            dpfm_pkg::ST_POS:
            begin
                span_reg <= span;
                idx_reg  <= '0;
                r_reg    <= '0;
            end
            dpfm_pkg::ST_IDX_WAIT:
                if (div_done)
                begin
                    idx_reg <= div_quot[dpfm_pkg::CV_IDX_W-1:0];
                    r_reg   <= div_rem;
                end
            dpfm_pkg::ST_RD_B:
                a_reg <= rdata_reg;
            dpfm_pkg::ST_INTERP:
            begin
                neg_reg <= (b_val < a_reg);
                cv_reg  <= a_reg;
            end
            dpfm_pkg::ST_CV_WAIT:
                if (div_done)
                begin
                    cv_reg <= neg_reg ? (a_reg - quot16) : (a_reg + quot16);
                end
            dpfm_pkg::ST_SQ_WAIT:
                if (sq_done)
                begin
                    s_reg <= sq_root;
                end
            dpfm_pkg::ST_MUL1:
                p1_reg <= 38'({22'b0, cv_reg} * {16'b0, s_reg});
            dpfm_pkg::ST_MUL2:
                p2_reg <= 54'({16'b0, p1_reg} * {38'b0, cfg.gal_to_ml});
            dpfm_pkg::ST_OUT:
                if (out_free)
                begin
                    out_reg.upstream_psi   <= up_reg;
                    out_reg.downstream_psi <= dn_reg;
                    out_reg.cv_interp      <= cv_reg;
                    out_reg.flow_ml_min    <= sat ? dpfm_pkg::FLOW_MAX : p2_reg[43:24];
                    out_reg.flow_saturated <= sat;
                end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    dpfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    dpfm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

endmodule

// ----- rtl/differential_pressure_flow_meter.sv -----
`timescale 1ns / 1ps
// Differential pressure flow meter.
// Input stream s_*: one word per item. s_tuser = 0 is a sample (two pressure
// pairs and a pot reading), s_tuser = 1 loads one Cv table entry.
// Output stream m_*: one word per sample, none per load.
// Config channel cfg_*: always ready, write only while the block is idle.
// A front register takes words into a four-word queue; the back end drains
// it one word at a time. A load is written to the Cv table while the back
// end stays idle. A sample holds the back end while it uses the shared
// divider two to four times (both pressures, then the table position unless
// the pot range is empty, then the interpolation unless the position falls
// on an entry) and the root unit (two radicand bits per cycle). Input is
// accepted while the back end works until the queue and the front register
// are full.
// When m_tready is low, the finished word waits in the output register and
// the back end stops only before it writes the next result.
// Reset empties the queue and the output and loads the register defaults;
// Cv entries are undefined until loaded.
module differential_pressure_flow_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // up_neg, up_pos, down_neg, down_pos, pot_reading,
                                   // cv_index, cv_entry
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // upstream_psi, downstream_psi, cv_interp, flow_ml_min
    output logic        m_tuser,   // flow_saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dpfm_pkg::cfg_t       cfg_reg;
    dpfm_pkg::fifo_stat_t fifo_stat;
    dpfm_pkg::item_t      push_item, head;
    dpfm_pkg::result_t    res;
    logic                 push, pop, held;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pot_min         <= 12'd0;
            cfg_reg.pot_max         <= 12'd4095;
            cfg_reg.cv_entries_used <= 5'd16;
            cfg_reg.adc_full_scale  <= 12'd4095;
            cfg_reg.full_scale_psi  <= 16'd25600;
            cfg_reg.sg_recip        <= 16'd4096;
            cfg_reg.gal_to_ml       <= 16'd3785;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dpfm_pkg::CFG_POT_MIN:        cfg_reg.pot_min         <= cfg_data[11:0];
                dpfm_pkg::CFG_POT_MAX:        cfg_reg.pot_max         <= cfg_data[11:0];
                dpfm_pkg::CFG_CV_ENTRIES:     cfg_reg.cv_entries_used <= cfg_data[4:0];
                dpfm_pkg::CFG_ADC_FULL_SCALE: cfg_reg.adc_full_scale  <= cfg_data[11:0];
                dpfm_pkg::CFG_FULL_SCALE_PSI: cfg_reg.full_scale_psi  <= cfg_data;
                dpfm_pkg::CFG_SG_RECIP:       cfg_reg.sg_recip        <= cfg_data;
                dpfm_pkg::CFG_GAL_TO_ML:      cfg_reg.gal_to_ml       <= cfg_data;
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    dpfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item),
        .held      (held)
    );

    dpfm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    dpfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'b0, res.flow_ml_min, res.cv_interp, res.downstream_psi,
                      res.upstream_psi};
    assign m_tuser = res.flow_saturated;

`ifndef NO_ASSERTIONS
    a_fifo_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue reports full and empty together");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (held && fifo_stat.full) |-> !s_tready)
        else $error("input taken while front and queue are full");

    a_sat_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[67:48] == dpfm_pkg::FLOW_MAX))
        else $error("saturated flow word not at maximum");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
